// ===== sv/gaussian_orbital_grid_evaluator_unit_defines.svh =====
// Assertion macros shared by the checker of the orbital grid evaluator.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef GAUSSIAN_ORBITAL_GRID_EVALUATOR_UNIT_DEFINES_SVH
`define GAUSSIAN_ORBITAL_GRID_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GOGE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GOGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/goge_pkg.sv =====
// Types, codes and fixed constants of the orbital grid evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package goge_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_CENTER_Z   = 3'd2;
  localparam logic [2:0] REG_POWER_X    = 3'd3;
  localparam logic [2:0] REG_POWER_Y    = 3'd4;
  localparam logic [2:0] REG_POWER_Z    = 3'd5;
  localparam logic [2:0] REG_PRIM_COUNT = 3'd6;

  // input word layout
  localparam int IN_DATA_W = 168;
  localparam int SLOT_LSB  = 0;
  localparam int EXP_LSB   = 3;
  localparam int COEF_LSB  = 35;
  localparam int PX_LSB    = 67;
  localparam int PY_LSB    = 99;
  localparam int PZ_LSB    = 131;
  localparam int KEEP_BIT  = 163;

  localparam int MUL_W = 35;

  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [24:0] ONE_Q24   = 25'h100_0000;
  localparam logic [3:0]  SER_TERMS = 4'd13;

  localparam logic [49:0] POS_LIMIT   = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [49:0] NEG_LIMIT   = 50'h0_8000_0000_0000;
  localparam logic [47:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OUT_NEG_MAX = 48'h8000_0000_0000;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [2:0]  power_x;
    logic [2:0]  power_y;
    logic [2:0]  power_z;
    logic [3:0]  prim_count;
  } goge_cfg_t;

  typedef struct packed {
    logic [31:0] expo;
    logic [31:0] coef;
  } goge_prim_t;

  typedef struct packed {
    logic [47:0] value;
    logic        sat;
  } goge_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_SQACC, ST_PRIM, ST_PHI, ST_PLO, ST_SMUL, ST_SDIV,
    ST_SCOR, ST_POW, ST_POWW, ST_TERM, ST_ACC, ST_ANG, ST_AM1, ST_AM2, ST_FIN
  } goge_state_t;

  // floor(2^34 / n): quotient estimate for the series divisions
  function automatic logic [34:0] goge_recip(input logic [3:0] n);
    logic [34:0] m;
    case (n)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623061;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973836;
      4'd6:    m = 35'd2863311530;
      4'd7:    m = 35'd2454267026;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874353;
      4'd10:   m = 35'd1717986918;
      4'd11:   m = 35'd1561806289;
      4'd12:   m = 35'd1431655765;
      4'd13:   m = 35'd1321528398;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/goge_cell.sv =====
// One cell of the primitive ring: holds an exponent and coefficient pair.
// Depends on goge_pkg.
`timescale 1ns / 1ps
module goge_cell import goge_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  logic       load,
  input  goge_prim_t load_prim,
  input  goge_prim_t nb_prim,
  output goge_prim_t prim
);

  goge_prim_t prim_r;

  // take a new entry, or advance the ring by one place
  always_ff @(posedge clk) begin
    if (load) begin
      prim_r <= load_prim;
    end else if (shift) begin
      prim_r <= nb_prim;
    end
  end

  assign prim = prim_r;

endmodule

// ===== sv/goge_eval.sv =====
// Sequencer and shared datapath that evaluates one grid point.
// Depends on goge_pkg; reads the primitive at the head of the cell ring.
`timescale 1ns / 1ps
module goge_eval import goge_pkg::*; #(
  parameter int MAX_PRIMS = 8,
  parameter int MAX_POWER = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        keep,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  input  goge_cfg_t   cfg,
  input  goge_prim_t  head,
  output logic        rotate,
  output logic        idle,
  input  logic        res_ready,
  output logic        res_valid,
  output goge_res_t   res
);

  localparam int CW = $clog2(MAX_PRIMS + 1);
  localparam int RADW = 49 + $clog2(MAX_PRIMS + 1);
  localparam logic [CW-1:0] P_END = CW'(MAX_PRIMS);
  localparam logic [2:0] MAXPW = 3'(MAX_POWER);

  goge_state_t state_r, state_nxt;

  logic [2*MUL_W-1:0] mul_r;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  logic [32:0]     mag_r [3];
  logic [2:0]      negd_r;
  logic [1:0]      ax_r;
  logic [41:0]     r2_r;
  logic [CW-1:0]   p_r;
  logic [RADW-1:0] radial_r;
  logic            flush_r;
  logic [21:0]     hi_r;
  logic [4:0]      k_r;
  logic [24:0]     f_r;
  logic [32:0]     term_r, s_r, x_r, e_r, e1_r;
  logic [3:0]      n_r;
  logic            second_r;
  logic [61:0]     v_r;
  logic            vneg_r;
  logic            over_r;
  logic [2:0]      j_r;
  logic [62:0]     p1_r;

  logic [32:0]     dx, dy, dz;
  logic [32:0]     mag_cur;
  logic            negd_cur;
  logic [2:0]      pw_cur;
  logic            p_done, p_use, mul_go;
  logic [53:0]     prod;
  logic            flush;
  logic [32:0]     qe, rem, q, s_new;
  logic [36:0]     qn;
  logic [34:0]     ss;
  logic [31:0]     cm, e_clamp;
  logic            c_neg;
  logic [47:0]     tm;
  logic [RADW-1:0] rad_mag;
  logic [71:0]     amr;
  logic [49:0]     res_mag;
  logic [49:0]     res_neg;

  function automatic logic [2:0] clamp_pw(input logic [2:0] pw);
    return (pw > MAXPW) ? MAXPW : pw;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] d);
    return d[32] ? (~d + 33'd1) : d;
  endfunction

  assign dx = {point_x[31], point_x} - {cfg.center_x[31], cfg.center_x};
  assign dy = {point_y[31], point_y} - {cfg.center_y[31], cfg.center_y};
  assign dz = {point_z[31], point_z} - {cfg.center_z[31], cfg.center_z};

  always_comb begin
    case (ax_r)
      2'd0: begin
        mag_cur  = mag_r[0];
        negd_cur = negd_r[0];
        pw_cur   = clamp_pw(cfg.power_x);
      end
      2'd1: begin
        mag_cur  = mag_r[1];
        negd_cur = negd_r[1];
        pw_cur   = clamp_pw(cfg.power_y);
      end
      default: begin
        mag_cur  = mag_r[2];
        negd_cur = negd_r[2];
        pw_cur   = clamp_pw(cfg.power_z);
      end
    endcase
  end

  assign p_done = (p_r == P_END);
  assign p_use  = (6'(p_r) < {2'b00, cfg.prim_count});
  assign mul_go = (j_r < pw_cur) && !over_r;

  // exponent argument a*r2 in Q.38; flush at 32 and above
  assign prod  = 54'({hi_r, 21'b0}) + mul_r[53:0];
  assign flush = flush_r || (|prod[53:43]);

  // series step: truncated quotient, then clamped partial sum
  assign qe    = mul_r[66:34];
  assign qn    = 37'(qe) * 37'(n_r);
  assign rem   = x_r - qn[32:0];
  assign q     = qe + {32'b0, (rem >= {29'b0, n_r})};
  assign ss    = n_r[0] ? ({2'b00, s_r} - {2'b00, q}) : ({2'b00, s_r} + {2'b00, q});
  assign s_new = ss[34] ? 33'd0 : ((ss > {2'b00, ONE_Q32}) ? ONE_Q32 : ss[32:0]);

  assign c_neg   = head.coef[31];
  assign cm      = c_neg ? (~head.coef + 32'd1) : head.coef;
  assign e_clamp = e_r[32] ? 32'hFFFF_FFFF : e_r[31:0];
  assign tm      = mul_r[63:16];
  assign rad_mag = radial_r[RADW-1] ? (~radial_r + RADW'(1)) : radial_r;

  assign amr = 72'({p1_r, 8'b0}) + 72'(mul_r[64:24]);

  // shared multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = MUL_W'(mag_cur);
        mul_b = MUL_W'(mag_cur);
      end
      ST_PRIM: begin
        mul_a = MUL_W'(head.expo);
        mul_b = MUL_W'(r2_r[41:21]);
      end
      ST_PHI: begin
        mul_a = MUL_W'(head.expo);
        mul_b = MUL_W'(r2_r[20:0]);
      end
      ST_SMUL: begin
        mul_a = MUL_W'(term_r);
        mul_b = MUL_W'(f_r);
      end
      ST_SDIV: begin
        mul_a = MUL_W'(mul_r[56:24]);
        mul_b = goge_recip(n_r);
      end
      ST_POW: begin
        mul_a = MUL_W'(e_r);
        mul_b = MUL_W'(e1_r);
      end
      ST_TERM: begin
        mul_a = MUL_W'(cm);
        mul_b = MUL_W'(e_clamp);
      end
      ST_ANG: begin
        mul_a = MUL_W'(v_r[61:32]);
        mul_b = MUL_W'(mag_cur);
      end
      ST_AM1: begin
        mul_a = MUL_W'(v_r[31:0]);
        mul_b = MUL_W'(mag_cur);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rotate    = 1'b0;
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_nxt = keep ? ST_SQ : ST_FIN;
        end
      end
      ST_SQ:    state_nxt = ST_SQACC;
      ST_SQACC: state_nxt = (ax_r == 2'd2) ? ST_PRIM : ST_SQ;
      ST_PRIM: begin
        if (p_done) begin
          state_nxt = ST_ANG;
        end else if (p_use) begin
          state_nxt = ST_PHI;
        end else begin
          rotate = 1'b1;
        end
      end
      ST_PHI:  state_nxt = ST_PLO;
      ST_PLO:  state_nxt = flush ? ST_TERM : ST_SMUL;
      ST_SMUL: state_nxt = ST_SDIV;
      ST_SDIV: state_nxt = ST_SCOR;
      ST_SCOR: begin
        if (n_r != SER_TERMS) begin
          state_nxt = ST_SMUL;
        end else if (second_r) begin
          state_nxt = ST_POW;
        end else begin
          state_nxt = (k_r == 5'd0) ? ST_TERM : ST_SMUL;
        end
      end
      ST_POW:  state_nxt = ST_POWW;
      ST_POWW: state_nxt = (k_r == 5'd1) ? ST_TERM : ST_POW;
      ST_TERM: state_nxt = ST_ACC;
      ST_ACC: begin
        rotate    = 1'b1;
        state_nxt = ST_PRIM;
      end
      ST_ANG: begin
        if (ax_r == 2'd3) begin
          state_nxt = ST_FIN;
        end else if (mul_go) begin
          state_nxt = ST_AM1;
        end
      end
      ST_AM1: state_nxt = ST_AM2;
      ST_AM2: state_nxt = ST_ANG;
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mag_r[0] <= abs33(dx);
          mag_r[1] <= abs33(dy);
          mag_r[2] <= abs33(dz);
          negd_r   <= {dz[32], dy[32], dx[32]};
          ax_r     <= 2'd0;
          r2_r     <= '0;
          v_r      <= '0;
          vneg_r   <= 1'b0;
          over_r   <= 1'b0;
        end
      end
      ST_SQACC: begin
        r2_r <= r2_r + 42'(mul_r[64:24]);
        ax_r <= ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          p_r      <= '0;
          radial_r <= '0;
        end
      end
      ST_PRIM: begin
        if (p_done) begin
          v_r    <= 62'(rad_mag);
          vneg_r <= radial_r[RADW-1];
          ax_r   <= 2'd0;
          j_r    <= 3'd0;
          over_r <= 1'b0;
        end else if (!p_use) begin
          p_r <= p_r + 1'b1;
        end
      end
      ST_PHI: begin
        flush_r <= |mul_r[52:22];
        hi_r    <= mul_r[21:0];
      end
      ST_PLO: begin
        k_r      <= prod[42:38];
        f_r      <= {1'b0, prod[37:14]};
        term_r   <= ONE_Q32;
        s_r      <= ONE_Q32;
        n_r      <= 4'd1;
        second_r <= 1'b0;
        e_r      <= '0;
      end
      ST_SDIV: x_r <= mul_r[56:24];
      ST_SCOR: begin
        term_r <= q;
        s_r    <= s_new;
        n_r    <= n_r + 4'd1;
        if (n_r == SER_TERMS) begin
          if (!second_r) begin
            // restart the series at a whole unit for the integer part
            e_r      <= s_new;
            f_r      <= ONE_Q24;
            term_r   <= ONE_Q32;
            s_r      <= ONE_Q32;
            n_r      <= 4'd1;
            second_r <= 1'b1;
          end else begin
            e1_r <= s_new;
          end
        end
      end
      ST_POWW: begin
        e_r <= mul_r[64:32];
        k_r <= k_r - 5'd1;
      end
      ST_ACC: begin
        radial_r <= c_neg ? (radial_r - RADW'(tm)) : (radial_r + RADW'(tm));
        p_r      <= p_r + 1'b1;
      end
      ST_ANG: begin
        if (ax_r != 2'd3 && !mul_go) begin
          vneg_r <= vneg_r ^ (negd_cur & pw_cur[0]);
          ax_r   <= ax_r + 2'd1;
          j_r    <= 3'd0;
        end
      end
      ST_AM1: p1_r <= mul_r[62:0];
      ST_AM2: begin
        if (|amr[71:62]) begin
          over_r <= 1'b1;
        end else begin
          v_r <= amr[61:0];
        end
        j_r <= j_r + 3'd1;
      end
      default: ;
    endcase
  end

  // drop to Q.24 and clamp to the signed 48-bit range
  assign res_mag = v_r[61:12];
  assign res_neg = ~res_mag + 50'd1;

  always_comb begin
    if (vneg_r) begin
      res.sat   = over_r || (res_mag > NEG_LIMIT);
      res.value = res.sat ? OUT_NEG_MAX : res_neg[47:0];
    end else begin
      res.sat   = over_r || (res_mag > POS_LIMIT);
      res.value = res.sat ? OUT_POS_MAX : res_mag[47:0];
    end
  end

endmodule

// ===== sv/gaussian_orbital_grid_evaluator_unit.sv =====
// Contracted Cartesian Gaussian orbital evaluator: top level.
// Channels: in_* stream takes load and point words, out_* stream returns
// one result word per point, cfg_* writes the centre, powers and count.
// A load word (in_tuser = load) writes one ring cell and
// produces no result; the next word is taken in the following cycle.
// A point word is evaluated one at a time by a sequencer around a single
// shared 35x35 multiplier. A screened point (keep clear) goes straight
// to a zero result. A kept point squares the three axis offsets; for each
// used primitive it runs the 13-term series on the fraction of a*r2 and,
// for a non-zero integer part k, raises a second series to the kth power
// (flushed at 32 and above), skipping unused ring places; it then multiplies
// in each axis offset once per unit of power, stopping early on overflow.
// Primitives sit in a ring of cells that rotates one place per primitive
// visited and comes back aligned after every point.
// Reset clears the sequencer, the output valid and the registers to their
// defaults (count one); the ring holds nothing defined until loaded.
// A stalled receiver holds the result register; the sequencer then waits
// in its final step, and in_tready stays low until the result can move.
`timescale 1ns / 1ps
module gaussian_orbital_grid_evaluator_unit import goge_pkg::*; #(
  parameter int MAX_PRIMS = 8,
  parameter int MAX_POWER = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // prim_slot, prim_exponent, prim_coeff, point_x, point_y, point_z, keep, pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // command
  input  logic [0:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // orbital_value
  output logic [47:0]          out_tdata,
  // saturated
  output logic [0:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [5:0] NP = 6'(MAX_PRIMS);

  goge_cfg_t  cfg_r;
  goge_prim_t ring [MAX_PRIMS];
  goge_prim_t load_prim;
  goge_res_t  res;

  logic       in_acc, load_word, start;
  logic [2:0] slot;
  logic       rotate, idle, res_valid, res_ready;
  logic       out_valid_r, out_sat_r;
  logic [47:0] out_value_r;

  assign cfg_ready = 1'b1;

  // register file; indices past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.center_z   <= '0;
      cfg_r.power_x    <= '0;
      cfg_r.power_y    <= '0;
      cfg_r.power_z    <= '0;
      cfg_r.prim_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:   cfg_r.center_x   <= cfg_data;
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_data;
        REG_CENTER_Z:   cfg_r.center_z   <= cfg_data;
        REG_POWER_X:    cfg_r.power_x    <= cfg_data[2:0];
        REG_POWER_Y:    cfg_r.power_y    <= cfg_data[2:0];
        REG_POWER_Z:    cfg_r.power_z    <= cfg_data[2:0];
        REG_PRIM_COUNT: cfg_r.prim_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_tready = idle;
  assign in_acc    = in_tvalid && in_tready;
  assign load_word = in_acc && (in_tuser[0] == CMD_LOAD);
  assign start     = in_acc && (in_tuser[0] == CMD_POINT);
  assign slot      = in_tdata[SLOT_LSB +: 3];

  assign load_prim.expo = in_tdata[EXP_LSB +: 32];
  assign load_prim.coef = in_tdata[COEF_LSB +: 32];

  // ring of primitive cells; cell 0 is the head seen by the sequencer
  for (genvar i = 0; i < MAX_PRIMS; i++) begin : g_cell
    goge_cell u_cell (
      .clk       (clk),
      .shift     (rotate),
      .load      (load_word && ({3'b000, slot} == 6'(i)) && ({3'b000, slot} < NP)),
      .load_prim (load_prim),
      .nb_prim   (ring[(i + 1) % MAX_PRIMS]),
      .prim      (ring[i])
    );
  end

  goge_eval #(
    .MAX_PRIMS (MAX_PRIMS),
    .MAX_POWER (MAX_POWER)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .keep      (in_tdata[KEEP_BIT]),
    .point_x   (in_tdata[PX_LSB +: 32]),
    .point_y   (in_tdata[PY_LSB +: 32]),
    .point_z   (in_tdata[PZ_LSB +: 32]),
    .cfg       (cfg_r),
    .head      (ring[0]),
    .rotate    (rotate),
    .idle      (idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: advance when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_sat_r;

endmodule

// ===== sv/goge_checker.sv =====
// Port-level checker for the orbital grid evaluator, bound to the top level.
// Depends on goge_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gaussian_orbital_grid_evaluator_unit_defines.svh"
module goge_checker import goge_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_DATA_W-1:0] in_tdata,
  input logic [0:0]           in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [47:0]          out_tdata,
  input logic [0:0]           out_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [2:0]           cfg_index,
  input logic [31:0]          cfg_data
);

  `GOGE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")
  `GOGE_ASSERT_NEXT(a_point_busy, in_tvalid && in_tready && (in_tuser[0] == CMD_POINT), !in_tready, "point word did not occupy the sequencer")
  `GOGE_ASSERT_NEXT(a_load_free, in_tvalid && in_tready && (in_tuser[0] == CMD_LOAD), in_tready, "load word blocked the input")
  `GOGE_ASSERT_IMPL(a_sat_limit, out_tvalid && out_tuser[0], (out_tdata == OUT_POS_MAX) || (out_tdata == OUT_NEG_MAX), "saturated word off the range limit")

endmodule

bind gaussian_orbital_grid_evaluator_unit goge_checker u_goge_checker (.*);
